// ----- rtl/particle_energy_power_reducer_unit_defines.svh -----
// Assertion macros for the particle energy and power reducer.
`ifndef PARTICLE_ENERGY_POWER_REDUCER_UNIT_DEFINES_SVH
`define PARTICLE_ENERGY_POWER_REDUCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PEPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PEPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pepr_pkg.sv -----
// Types and constants shared by the particle energy and power reducer.
`timescale 1ns / 1ps
`default_nettype none

package pepr_pkg;

    localparam int TYPE_W     = 8;
    localparam int DENS_W     = 24;
    localparam int VOL_W      = 32;
    localparam int COMP_W     = 32;
    localparam int OP_W       = COMP_W + 1;
    localparam int MASS_W     = DENS_W + VOL_W;
    localparam int PROD_W     = 64;
    localparam int DOT_W      = PROD_W + 1;
    localparam int MAG_W      = 64;
    localparam int WIDE_W     = MASS_W + MAG_W;
    localparam int SUM_W      = 64;
    localparam int KE_W       = 63;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_COMP   = 3;
    localparam int NUM_VEC    = 3;
    localparam int NUM_LANES  = 3;

    // Vector order in an item; lane n multiplies vector n by the velocity.
    localparam int VEC_VEL     = 0;
    localparam int LANE_ENERGY = 0;

    // Fraction bits dropped from the wide product of each lane.
    localparam int KE_SHIFT = 41;
    localparam int PW_SHIFT = 40;

    localparam int IN_DATA_W  = ((DENS_W + NUM_VEC * NUM_COMP * COMP_W + 7) / 8) * 8;
    localparam int RES_W      = KE_W + 2 * SUM_W + CNT_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FLUID_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 2'd1;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD0,
        ST_PROD1,
        ST_PROD2,
        ST_DOT_LAST,
        ST_ABS,
        ST_WIDE0,
        ST_WIDE1,
        ST_WIDE2,
        ST_WIDE3,
        ST_WIDE4,
        ST_TERM,
        ST_ACC,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        MUL_X,
        MUL_Y,
        MUL_Z,
        MUL_LL,
        MUL_LH,
        MUL_HL,
        MUL_HH
    } t_mul_sel;

    typedef enum logic [1:0] {
        DOT_HOLD,
        DOT_LOAD,
        DOT_ADD
    } t_dot_op;

    typedef enum logic [1:0] {
        WIDE_HOLD,
        WIDE_LOAD0,
        WIDE_ADD32,
        WIDE_ADD64
    } t_wide_op;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        t_dot_op  dot_op;
        logic     abs_en;
        t_wide_op wide_op;
        logic     term_en;
        logic     acc_en;
        logic     out_load;
        logic     sum_clr;
    } t_cmd;

    typedef struct packed {
        logic use_item;
        logic last;
    } t_status;

    typedef struct packed {
        logic [TYPE_W-1:0]                              particle_type;
        logic [DENS_W-1:0]                              density;
        logic [NUM_VEC-1:0][NUM_COMP-1:0][COMP_W-1:0]   vec;
        logic                                           last_particle;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] fluid_count;
        logic [SUM_W-1:0] capillary_power;
        logic [SUM_W-1:0] viscous_power;
        logic [KE_W-1:0]  kinetic_energy;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/pepr_ctrl.sv -----
// Sequencer that steps the reducer datapath through one record at a time.
`timescale 1ns / 1ps
`default_nettype none

module pepr_ctrl
    import pepr_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_X;
        o_cmd.dot_op   = DOT_HOLD;
        o_cmd.wide_op  = WIDE_HOLD;
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PROD0;
                end
            end
            ST_PROD0: begin
                o_cmd.mul_sel = MUL_X;
                n_state       = ST_PROD1;
            end
            ST_PROD1: begin
                // Mass is known here, so a record that does not count stops early.
                o_cmd.mul_sel = MUL_Y;
                o_cmd.dot_op  = DOT_LOAD;
                n_state       = i_status.use_item ? ST_PROD2 : ST_FIN;
            end
            ST_PROD2: begin
                o_cmd.mul_sel = MUL_Z;
                o_cmd.dot_op  = DOT_ADD;
                n_state       = ST_DOT_LAST;
            end
            ST_DOT_LAST: begin
                o_cmd.dot_op = DOT_ADD;
                n_state      = ST_ABS;
            end
            ST_ABS: begin
                o_cmd.abs_en = 1'b1;
                n_state      = ST_WIDE0;
            end
            ST_WIDE0: begin
                o_cmd.mul_sel = MUL_LL;
                n_state       = ST_WIDE1;
            end
            ST_WIDE1: begin
                o_cmd.mul_sel = MUL_LH;
                o_cmd.wide_op = WIDE_LOAD0;
                n_state       = ST_WIDE2;
            end
            ST_WIDE2: begin
                o_cmd.mul_sel = MUL_HL;
                o_cmd.wide_op = WIDE_ADD32;
                n_state       = ST_WIDE3;
            end
            ST_WIDE3: begin
                o_cmd.mul_sel = MUL_HH;
                o_cmd.wide_op = WIDE_ADD32;
                n_state       = ST_WIDE4;
            end
            ST_WIDE4: begin
                o_cmd.wide_op = WIDE_ADD64;
                n_state       = ST_TERM;
            end
            ST_TERM: begin
                o_cmd.term_en = 1'b1;
                n_state       = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                if (!i_status.last) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.sum_clr  = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pepr_datapath.sv -----
// Datapath of the reducer: three multiply lanes, wide products, saturating sums.
`timescale 1ns / 1ps
`default_nettype none

module pepr_datapath
    import pepr_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_item                  i_item,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output t_result                o_result
);

    // Configuration.
    logic [TYPE_W-1:0] r_fluid_type;
    logic [VOL_W-1:0]  r_volume;

    // Captured record.
    logic [TYPE_W-1:0]                            r_type;
    logic [DENS_W-1:0]                            r_density;
    logic [NUM_VEC-1:0][NUM_COMP-1:0][COMP_W-1:0] r_vec;
    logic                                         r_last;

    // Working registers.
    logic [MASS_W-1:0]        r_mass;
    logic [PROD_W-1:0]        r_prod [NUM_LANES];
    logic signed [DOT_W-1:0]  r_dot  [NUM_LANES];
    logic [MAG_W-1:0]         r_mag  [NUM_LANES];
    logic                     r_neg  [NUM_LANES];
    logic [WIDE_W-1:0]        r_wide [NUM_LANES];
    logic [SUM_W-1:0]         r_term [NUM_LANES];
    logic [SUM_W-1:0]         r_sum  [NUM_LANES];
    logic [CNT_W-1:0]         r_count;
    logic [SUM_W-1:0]         r_out_sum [NUM_LANES];
    logic [CNT_W-1:0]         r_out_count;

    logic signed [OP_W-1:0]   w_op_a [NUM_LANES];
    logic signed [OP_W-1:0]   w_op_b [NUM_LANES];
    logic signed [2*OP_W-1:0] w_prod [NUM_LANES];
    logic [DOT_W-1:0]         w_dot_neg [NUM_LANES];
    logic [SUM_W-1:0]         w_term [NUM_LANES];
    logic [SUM_W:0]           w_sum_ext [NUM_LANES];
    logic [SUM_W-1:0]         w_sum_sat [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fluid_type <= '0;
            r_volume     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FLUID_TYPE: r_fluid_type <= i_cfg_data[TYPE_W-1:0];
                CFG_VOLUME:     r_volume     <= i_cfg_data[VOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type    <= i_item.particle_type;
            r_density <= i_item.density;
            r_vec     <= i_item.vec;
            r_last    <= i_item.last_particle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mass <= r_density * r_volume;
    end

    assign o_status.use_item = (r_type == r_fluid_type) && (r_mass != '0);
    assign o_status.last     = r_last;

    // Operand selection: signed components first, then unsigned low and high parts of mass and magnitude.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            unique case (i_cmd.mul_sel)
                MUL_X: begin
                    w_op_a[l] = {r_vec[l][0][COMP_W-1], r_vec[l][0]};
                    w_op_b[l] = {r_vec[VEC_VEL][0][COMP_W-1], r_vec[VEC_VEL][0]};
                end
                MUL_Y: begin
                    w_op_a[l] = {r_vec[l][1][COMP_W-1], r_vec[l][1]};
                    w_op_b[l] = {r_vec[VEC_VEL][1][COMP_W-1], r_vec[VEC_VEL][1]};
                end
                MUL_Z: begin
                    w_op_a[l] = {r_vec[l][2][COMP_W-1], r_vec[l][2]};
                    w_op_b[l] = {r_vec[VEC_VEL][2][COMP_W-1], r_vec[VEC_VEL][2]};
                end
                MUL_LL: begin
                    w_op_a[l] = {1'b0, r_mass[31:0]};
                    w_op_b[l] = {1'b0, r_mag[l][31:0]};
                end
                MUL_LH: begin
                    w_op_a[l] = {1'b0, r_mass[31:0]};
                    w_op_b[l] = {1'b0, r_mag[l][MAG_W-1:32]};
                end
                MUL_HL: begin
                    w_op_a[l] = {{(OP_W-(MASS_W-32)){1'b0}}, r_mass[MASS_W-1:32]};
                    w_op_b[l] = {1'b0, r_mag[l][31:0]};
                end
                MUL_HH: begin
                    w_op_a[l] = {{(OP_W-(MASS_W-32)){1'b0}}, r_mass[MASS_W-1:32]};
                    w_op_b[l] = {1'b0, r_mag[l][MAG_W-1:32]};
                end
                default: begin
                    w_op_a[l] = '0;
                    w_op_b[l] = '0;
                end
            endcase
            w_prod[l] = w_op_a[l] * w_op_b[l];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            r_prod[l] <= w_prod[l][PROD_W-1:0];
        end
    end

    // Dot product, magnitude and sign.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_dot_neg[l] = -r_dot[l];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            unique case (i_cmd.dot_op)
                DOT_LOAD: r_dot[l] <= {r_prod[l][PROD_W-1], r_prod[l]};
                DOT_ADD:  r_dot[l] <= r_dot[l] + {r_prod[l][PROD_W-1], r_prod[l]};
                default:  r_dot[l] <= r_dot[l];
            endcase
            if (i_cmd.abs_en) begin
                r_neg[l] <= r_dot[l][DOT_W-1];
                r_mag[l] <= r_dot[l][DOT_W-1] ? w_dot_neg[l][MAG_W-1:0] : r_dot[l][MAG_W-1:0];
            end
        end
    end

    // Wide product of mass and magnitude, built from four partial products.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            unique case (i_cmd.wide_op)
                WIDE_LOAD0: r_wide[l] <= {{(WIDE_W-PROD_W){1'b0}}, r_prod[l]};
                WIDE_ADD32: r_wide[l] <= r_wide[l]
                                         + {{(WIDE_W-PROD_W-32){1'b0}}, r_prod[l], 32'b0};
                WIDE_ADD64: r_wide[l] <= r_wide[l]
                                         + {r_prod[l][WIDE_W-64-1:0], 64'b0};
                default:    r_wide[l] <= r_wide[l];
            endcase
        end
    end

    // Scaled and saturated term; the energy lane also takes the factor of one half.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            logic            ovf;
            logic [KE_W-1:0] mag63;
            if (l == LANE_ENERGY) begin
                ovf   = |r_wide[l][WIDE_W-1:KE_SHIFT+KE_W];
                mag63 = r_wide[l][KE_SHIFT+KE_W-1:KE_SHIFT];
            end else begin
                ovf   = |r_wide[l][WIDE_W-1:PW_SHIFT+KE_W];
                mag63 = r_wide[l][PW_SHIFT+KE_W-1:PW_SHIFT];
            end
            if (!r_neg[l]) begin
                w_term[l] = ovf ? SUM_MAX : {1'b0, mag63};
            end else begin
                w_term[l] = ovf ? SUM_MIN : -{1'b0, mag63};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.term_en) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_term[l] <= w_term[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_sum_ext[l] = {r_sum[l][SUM_W-1], r_sum[l]} + {r_term[l][SUM_W-1], r_term[l]};
            if (w_sum_ext[l][SUM_W] != w_sum_ext[l][SUM_W-1]) begin
                w_sum_sat[l] = w_sum_ext[l][SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                w_sum_sat[l] = w_sum_ext[l][SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_sum[l] <= '0;
            end
            r_count <= '0;
        end else if (i_cmd.sum_clr) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_sum[l] <= '0;
            end
            r_count <= '0;
        end else if (i_cmd.acc_en) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_sum[l] <= w_sum_sat[l];
            end
            if (r_count != CNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_out_sum[l] <= r_sum[l];
            end
            r_out_count <= r_count;
        end
    end

    assign o_result.kinetic_energy  = r_out_sum[0][KE_W-1:0];
    assign o_result.viscous_power   = r_out_sum[1];
    assign o_result.capillary_power = r_out_sum[2];
    assign o_result.fluid_count     = r_out_count;

endmodule

`default_nettype wire

// ----- rtl/particle_energy_power_reducer_unit.sv -----
// Particle energy and power reducer: sums kinetic energy and viscous and
// capillary power over a run of particle records and emits the totals on the
// record marked last. Records are taken one at a time: a record whose type
// differs from the fluid type, or whose mass is zero, stops early once its mass
// is known; a counted record passes through three shared 33 by 33 bit
// multipliers that form the three products of each dot product and then the
// four partial products of mass times that result. A last record waits in its
// final step until the result register is free. Results sit in an output
// register, so a new record is taken while a result still waits for its transfer.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_energy_power_reducer_unit_defines.svh"

module particle_energy_power_reducer_unit
    import pepr_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Configuration write channel.
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]   i_cfg_data,
    // Record stream.
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    // From bit 0: density, vel_x, vel_y, vel_z, visc_acc_x, visc_acc_y,
    // visc_acc_z, cap_acc_x, cap_acc_y, cap_acc_z.
    input  wire  [IN_DATA_W-1:0]    i_s_tdata,
    // particle_type.
    input  wire  [TYPE_W-1:0]       i_s_tuser,
    input  wire                     i_s_tlast,
    // Result stream.
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    // From bit 0: kinetic_energy, viscous_power, capillary_power, fluid_count,
    // one zero pad bit.
    output logic [OUT_DATA_W-1:0]   o_m_tdata
);

    t_item   w_item;
    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_item.particle_type = i_s_tuser;
        w_item.density       = i_s_tdata[DENS_W-1:0];
        w_item.last_particle = i_s_tlast;
        for (int v = 0; v < NUM_VEC; v++) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                w_item.vec[v][c] = i_s_tdata[DENS_W + COMP_W*(NUM_COMP*v + c) +: COMP_W];
            end
        end
    end

    pepr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pepr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (w_result)
    );

    assign o_m_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, w_result};

    `PEPR_ASSERT_SAME(a_result_slot_free, w_cmd.out_load, !o_m_tvalid || i_m_tready,
        "result loaded while the previous one was still waiting")
    `PEPR_ASSERT_NEXT(a_one_record_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready,
        "record taken while the previous one was still in work")
    `PEPR_ASSERT_NEXT(a_result_presented, w_cmd.out_load, o_m_tvalid,
        "loaded result not presented on the output")

endmodule

`default_nettype wire
